// ===== hdl/dpp_pkg.sv =====
// Shared types, constants and helpers of the DHCP packet parser.
`default_nettype none
package dpp_pkg;

    localparam int MAX_PACKET_DEF = 2048;
    localparam int CFG_W          = 12;
    localparam int CFG_IDX_W      = 2;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_W     = 2;
    localparam int FIFO_CNT_W     = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 2'd1;
    localparam logic [CFG_W-1:0]     MIN_LEN_RST    = 12'd236;
    localparam logic [CFG_W-1:0]     MAX_LEN_RST    = 12'd1500;

    localparam int COOKIE_AT  = 236;
    localparam int OPTIONS_AT = 240;

    localparam logic [7:0] OPT_PAD       = 8'd0;
    localparam logic [7:0] OPT_END       = 8'd255;
    localparam logic [7:0] OPT_REQUESTED = 8'd50;
    localparam logic [7:0] OPT_SERVER_ID = 8'd54;
    localparam logic [7:0] OPT_ADDR_LEN  = 8'd4;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_SHORT  = 2'd1,
        ST_LONG   = 2'd2,
        ST_COOKIE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        LEN_OK,
        LEN_SHORT,
        LEN_LONG,
        LEN_NO_OPTS
    } t_len_check;

    typedef enum logic [3:0] {
        FC_NONE,
        FC_OP,
        FC_HTYPE,
        FC_HLEN,
        FC_XID,
        FC_BCAST,
        FC_RELAY,
        FC_CHADDR,
        FC_COOKIE,
        FC_OPTION
    } t_field_class;

    typedef enum logic [1:0] {
        PH_CODE,
        PH_LEN,
        PH_VALUE,
        PH_DONE
    } t_opt_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     value;
    } t_cfg_item;

    typedef struct packed {
        t_status     status;
        logic [7:0]  op_code;
        logic [7:0]  hw_type;
        logic [7:0]  hw_len;
        logic [31:0] transaction_id;
        logic        broadcast;
        logic [31:0] relay_addr;
        logic [47:0] client_hw;
        logic [31:0] requested_ip;
        logic        requested_found;
        logic [31:0] server_id;
        logic        server_found;
    } t_res_item;

    typedef struct packed {
        logic [7:0]   data_byte;
        logic         last;
        t_field_class cls;
        logic [1:0]   cookie_idx;
        t_len_check   len_chk;
    } t_work_item;

    function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = 8'h63;
            2'd1:    v = 8'h82;
            2'd2:    v = 8'h53;
            default: v = 8'h63;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/dpp_stream_if.sv =====
// Valid/ready channel interface carrying one payload of a chosen type.
`default_nettype none
interface dpp_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/dpp_front.sv =====
// Front end: byte counter, field classification and length verdict.
`default_nettype none
module dpp_front #(
    parameter int MAX_PACKET = dpp_pkg::MAX_PACKET_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    dpp_stream_if.sink                      i_in,
    input  wire logic [dpp_pkg::CFG_W-1:0]  i_min_len,
    input  wire logic [dpp_pkg::CFG_W-1:0]  i_max_len,
    output      logic                       o_wr_valid,
    output      dpp_pkg::t_work_item        o_wr_item,
    input  wire logic                       i_wr_ready
);
    localparam int CNT_W = $clog2(MAX_PACKET + 2);
    localparam int LW    = (CNT_W > dpp_pkg::CFG_W) ? CNT_W : dpp_pkg::CFG_W;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] count_after;
    logic             take;
    logic             accept;
    dpp_pkg::t_field_class cls;
    dpp_pkg::t_len_check   len_chk;

    assign accept     = i_in.valid && i_wr_ready;
    assign i_in.ready = i_wr_ready;
    assign o_wr_valid = i_in.valid;

    assign take        = r_count < CNT_W'(MAX_PACKET);
    assign count_after = (r_count < CNT_W'(MAX_PACKET + 1)) ? r_count + CNT_W'(1) : r_count;

    always_comb begin
        cls = dpp_pkg::FC_NONE;
        if (take) begin
            if (r_count == CNT_W'(0))                                  cls = dpp_pkg::FC_OP;
            else if (r_count == CNT_W'(1))                             cls = dpp_pkg::FC_HTYPE;
            else if (r_count == CNT_W'(2))                             cls = dpp_pkg::FC_HLEN;
            else if (r_count >= CNT_W'(4) && r_count <= CNT_W'(7))     cls = dpp_pkg::FC_XID;
            else if (r_count == CNT_W'(10))                            cls = dpp_pkg::FC_BCAST;
            else if (r_count >= CNT_W'(24) && r_count <= CNT_W'(27))   cls = dpp_pkg::FC_RELAY;
            else if (r_count >= CNT_W'(28) && r_count <= CNT_W'(33))   cls = dpp_pkg::FC_CHADDR;
            else if (r_count >= CNT_W'(dpp_pkg::COOKIE_AT) &&
                     r_count <  CNT_W'(dpp_pkg::OPTIONS_AT))           cls = dpp_pkg::FC_COOKIE;
            else if (r_count >= CNT_W'(dpp_pkg::OPTIONS_AT))           cls = dpp_pkg::FC_OPTION;
        end
    end

    always_comb begin
        if (LW'(count_after) < LW'(i_min_len)) begin
            len_chk = dpp_pkg::LEN_SHORT;
        end else if (LW'(count_after) > LW'(i_max_len)) begin
            len_chk = dpp_pkg::LEN_LONG;
        end else if (count_after < CNT_W'(dpp_pkg::OPTIONS_AT)) begin
            len_chk = dpp_pkg::LEN_NO_OPTS;
        end else begin
            len_chk = dpp_pkg::LEN_OK;
        end
    end

    always_comb begin
        o_wr_item.data_byte  = i_in.payload.data_byte;
        o_wr_item.last       = i_in.payload.last;
        o_wr_item.cls        = cls;
        o_wr_item.cookie_idx = r_count[1:0];
        o_wr_item.len_chk    = len_chk;
    end

    always_comb begin
        n_count = r_count;
        if (accept) begin
            n_count = i_in.payload.last ? '0 : count_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/dpp_fifo.sv =====
// Short queue of classified bytes between front and back.
`default_nettype none
module dpp_fifo (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr_valid,
    input  wire dpp_pkg::t_work_item  i_wr_item,
    output      logic                 o_wr_ready,
    output      logic                 o_rd_valid,
    output      dpp_pkg::t_work_item  o_rd_item,
    input  wire logic                 i_rd_pop
);
    dpp_pkg::t_work_item r_mem [dpp_pkg::FIFO_DEPTH];
    logic [dpp_pkg::FIFO_PTR_W-1:0] r_wr_ptr;
    logic [dpp_pkg::FIFO_PTR_W-1:0] r_rd_ptr;
    logic [dpp_pkg::FIFO_CNT_W-1:0] r_cnt;
    logic push;
    logic pop;

    assign o_wr_ready = r_cnt != dpp_pkg::FIFO_CNT_W'(dpp_pkg::FIFO_DEPTH);
    assign o_rd_valid = r_cnt != '0;
    assign o_rd_item  = r_mem[r_rd_ptr];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = i_rd_pop && o_rd_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + dpp_pkg::FIFO_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + dpp_pkg::FIFO_PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + dpp_pkg::FIFO_CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - dpp_pkg::FIFO_CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hdl/dpp_back.sv =====
// Back end: header capture, cookie check, option walk and result register.
`default_nettype none
module dpp_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_rd_valid,
    input  wire dpp_pkg::t_work_item  i_rd_item,
    output      logic                 o_rd_pop,
    dpp_stream_if.source              o_res
);
    logic [7:0]  r_op,    n_op;
    logic [7:0]  r_htype, n_htype;
    logic [7:0]  r_hlen,  n_hlen;
    logic [31:0] r_xid,   n_xid;
    logic        r_bcast, n_bcast;
    logic [31:0] r_relay, n_relay;
    logic [47:0] r_chaddr, n_chaddr;
    logic        r_cookie_ok, n_cookie_ok;
    dpp_pkg::t_opt_phase r_phase, n_phase;
    logic [7:0]  r_code,  n_code;
    logic [7:0]  r_left,  n_left;
    logic [31:0] r_value, n_value;
    logic [31:0] r_req,   n_req;
    logic        r_req_seen, n_req_seen;
    logic [31:0] r_srv,   n_srv;
    logic        r_srv_seen, n_srv_seen;

    dpp_pkg::t_res_item r_res, n_res;
    logic               r_res_valid;

    logic       slot_free;
    logic       opt_byte;
    logic [7:0] b;
    logic [7:0] left_dec;
    logic       addr_opt;

    assign slot_free = !r_res_valid || o_res.ready;
    assign o_rd_pop  = i_rd_valid && (!i_rd_item.last || slot_free);
    assign opt_byte  = o_rd_pop && (i_rd_item.cls == dpp_pkg::FC_OPTION);
    assign b         = i_rd_item.data_byte;
    assign left_dec  = r_left - 8'd1;
    assign addr_opt  = (r_code == dpp_pkg::OPT_REQUESTED) || (r_code == dpp_pkg::OPT_SERVER_ID);

    assign o_res.valid   = r_res_valid;
    assign o_res.payload = r_res;

    // Option walk: next phase
    always_comb begin
        n_phase = r_phase;
        if (opt_byte) begin
            case (r_phase)
                dpp_pkg::PH_CODE: begin
                    if (b == dpp_pkg::OPT_END) begin
                        n_phase = dpp_pkg::PH_DONE;
                    end else if (b != dpp_pkg::OPT_PAD) begin
                        n_phase = dpp_pkg::PH_LEN;
                    end
                end
                dpp_pkg::PH_LEN: begin
                    n_phase = (b == 8'd0) ? dpp_pkg::PH_CODE : dpp_pkg::PH_VALUE;
                end
                dpp_pkg::PH_VALUE: begin
                    if (left_dec == 8'd0) begin
                        n_phase = dpp_pkg::PH_CODE;
                    end
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    // Field capture and option datapath
    always_comb begin
        n_op        = r_op;
        n_htype     = r_htype;
        n_hlen      = r_hlen;
        n_xid       = r_xid;
        n_bcast     = r_bcast;
        n_relay     = r_relay;
        n_chaddr    = r_chaddr;
        n_cookie_ok = r_cookie_ok;
        n_code      = r_code;
        n_left      = r_left;
        n_value     = r_value;
        n_req       = r_req;
        n_req_seen  = r_req_seen;
        n_srv       = r_srv;
        n_srv_seen  = r_srv_seen;
        if (o_rd_pop) begin
            case (i_rd_item.cls)
                dpp_pkg::FC_OP:     n_op     = b;
                dpp_pkg::FC_HTYPE:  n_htype  = b;
                dpp_pkg::FC_HLEN:   n_hlen   = b;
                dpp_pkg::FC_XID:    n_xid    = {r_xid[23:0], b};
                dpp_pkg::FC_BCAST:  n_bcast  = b[7];
                dpp_pkg::FC_RELAY:  n_relay  = {r_relay[23:0], b};
                dpp_pkg::FC_CHADDR: n_chaddr = {r_chaddr[39:0], b};
                dpp_pkg::FC_COOKIE: begin
                    if (b != dpp_pkg::cookie_byte(i_rd_item.cookie_idx)) begin
                        n_cookie_ok = 1'b0;
                    end
                end
                dpp_pkg::FC_OPTION: begin
                    case (r_phase)
                        dpp_pkg::PH_CODE: begin
                            if (b != dpp_pkg::OPT_END && b != dpp_pkg::OPT_PAD) begin
                                n_code = b;
                            end
                        end
                        dpp_pkg::PH_LEN: begin
                            if (b != dpp_pkg::OPT_ADDR_LEN || !addr_opt) begin
                                n_code = 8'd0;
                            end
                            n_left  = b;
                            n_value = '0;
                        end
                        dpp_pkg::PH_VALUE: begin
                            n_value = {r_value[23:0], b};
                            n_left  = left_dec;
                            if (left_dec == 8'd0) begin
                                if (r_code == dpp_pkg::OPT_REQUESTED && !r_req_seen) begin
                                    n_req      = {r_value[23:0], b};
                                    n_req_seen = 1'b1;
                                end else if (r_code == dpp_pkg::OPT_SERVER_ID && !r_srv_seen) begin
                                    n_srv      = {r_value[23:0], b};
                                    n_srv_seen = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_res = '0;
        case (i_rd_item.len_chk)
            dpp_pkg::LEN_SHORT:   n_res.status = dpp_pkg::ST_SHORT;
            dpp_pkg::LEN_LONG:    n_res.status = dpp_pkg::ST_LONG;
            dpp_pkg::LEN_NO_OPTS: n_res.status = dpp_pkg::ST_COOKIE;
            default:              n_res.status = n_cookie_ok ? dpp_pkg::ST_OK : dpp_pkg::ST_COOKIE;
        endcase
        if (n_res.status == dpp_pkg::ST_OK) begin
            n_res.op_code         = n_op;
            n_res.hw_type         = n_htype;
            n_res.hw_len          = n_hlen;
            n_res.transaction_id  = n_xid;
            n_res.broadcast       = n_bcast;
            n_res.relay_addr      = n_relay;
            n_res.client_hw       = n_chaddr;
            n_res.requested_ip    = n_req;
            n_res.requested_found = n_req_seen;
            n_res.server_id       = n_srv;
            n_res.server_found    = n_srv_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rd_pop && i_rd_item.last) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (o_rd_pop && i_rd_item.last) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_rd_pop && i_rd_item.last)) begin
            r_op        <= '0;
            r_htype     <= '0;
            r_hlen      <= '0;
            r_xid       <= '0;
            r_bcast     <= 1'b0;
            r_relay     <= '0;
            r_chaddr    <= '0;
            r_cookie_ok <= 1'b1;
            r_phase     <= dpp_pkg::PH_CODE;
            r_code      <= '0;
            r_left      <= '0;
            r_value     <= '0;
            r_req       <= '0;
            r_req_seen  <= 1'b0;
            r_srv       <= '0;
            r_srv_seen  <= 1'b0;
        end else begin
            r_op        <= n_op;
            r_htype     <= n_htype;
            r_hlen      <= n_hlen;
            r_xid       <= n_xid;
            r_bcast     <= n_bcast;
            r_relay     <= n_relay;
            r_chaddr    <= n_chaddr;
            r_cookie_ok <= n_cookie_ok;
            r_phase     <= n_phase;
            r_code      <= n_code;
            r_left      <= n_left;
            r_value     <= n_value;
            r_req       <= n_req;
            r_req_seen  <= n_req_seen;
            r_srv       <= n_srv;
            r_srv_seen  <= n_srv_seen;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/dhcp_packet_parser_top.sv =====
// Top level of the DHCP/BOOTP packet parser.
//
//  channel  dir  payload                         transfer
//  i_in     in   data_byte[7:0], last            valid && ready
//  i_cfg    in   index[1:0], value[11:0]         valid && ready (ready tied high)
//  o_res    out  status, header fields, options  valid && ready
//
//  One byte a cycle while the queue has room; results are registered after the queue.
//  The front counts and classifies bytes into a four-entry queue; the back
//  captures fields and walks options, holding a result in its output register.
//  A stalled result blocks only the next last byte; ready drops when the queue fills.
//  Reset is synchronous: lengths return to 236 and 1500, all packet state clears.
`default_nettype none
module dhcp_packet_parser_top #(
    parameter int MAX_PACKET = dpp_pkg::MAX_PACKET_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    dpp_stream_if.sink    i_in,
    dpp_stream_if.sink    i_cfg,
    dpp_stream_if.source  o_res
);
    logic [dpp_pkg::CFG_W-1:0] r_min_len;
    logic [dpp_pkg::CFG_W-1:0] r_max_len;

    logic                wr_valid;
    logic                wr_ready;
    dpp_pkg::t_work_item wr_item;
    logic                rd_valid;
    logic                rd_pop;
    dpp_pkg::t_work_item rd_item;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= dpp_pkg::MIN_LEN_RST;
            r_max_len <= dpp_pkg::MAX_LEN_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.payload.index)
                dpp_pkg::CFG_MIN_LENGTH: r_min_len <= i_cfg.payload.value;
                dpp_pkg::CFG_MAX_LENGTH: r_max_len <= i_cfg.payload.value;
                default: ;
            endcase
        end
    end

    dpp_front #(
        .MAX_PACKET (MAX_PACKET)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_min_len  (r_min_len),
        .i_max_len  (r_max_len),
        .o_wr_valid (wr_valid),
        .o_wr_item  (wr_item),
        .i_wr_ready (wr_ready)
    );

    dpp_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (wr_valid),
        .i_wr_item  (wr_item),
        .o_wr_ready (wr_ready),
        .o_rd_valid (rd_valid),
        .o_rd_item  (rd_item),
        .i_rd_pop   (rd_pop)
    );

    dpp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_valid (rd_valid),
        .i_rd_item  (rd_item),
        .o_rd_pop   (rd_pop),
        .o_res      (o_res)
    );
endmodule
`default_nettype wire

// ===== hdl/dpp_checker.sv =====
// Port-level assertions on the packet parser and their binding.
`default_nettype none
module dpp_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_res_valid,
    input wire logic               i_res_ready,
    input wire dpp_pkg::t_res_item i_res
);
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res))
        else $error("result dropped or changed while stalled");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res.status != dpp_pkg::ST_OK |->
            i_res.op_code == '0 && i_res.hw_type == '0 && i_res.hw_len == '0 &&
            i_res.transaction_id == '0 && !i_res.broadcast && i_res.relay_addr == '0 &&
            i_res.client_hw == '0 && !i_res.requested_found && !i_res.server_found)
        else $error("rejected result carries field data");

    a_opt_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res.requested_found || i_res.requested_ip == '0) &&
                        (i_res.server_found || i_res.server_id == '0))
        else $error("option value without found flag");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");
endmodule

bind dhcp_packet_parser_top dpp_checker u_dpp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res       (o_res.payload)
);
`default_nettype wire
